FILE: rtl/dpsc_pkg.sv
// Package for the dual PI speed controller: fixed-point widths, scaling
// constants, register index codes, reset values and shared structs.
// No dependencies; every other file of the block imports it.
package dpsc_pkg;

  // Fixed-point scaling
  localparam int unsigned DUTY_RANGE      = 250;
  localparam int unsigned SPEED_FRAC_BITS = 12;
  localparam int unsigned GAIN_FRAC_BITS  = 20;
  localparam int unsigned SCALE_SHIFT     = SPEED_FRAC_BITS + GAIN_FRAC_BITS;

  // Field widths
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned LIM_W   = 23;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned SLEW_W  = 9;
  localparam int unsigned DUTY_W  = 9;
  localparam int unsigned PWM_W   = 8;

  // Datapath widths
  localparam int unsigned ERR_W   = SPEED_W + 1;
  localparam int unsigned INTEG_W = SPEED_W;
  localparam int unsigned ISUM_W  = INTEG_W + 2;
  localparam int unsigned PROD_W  = GAIN_W + 1 + ERR_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned ABS_W   = PROD_W;
  localparam int unsigned RANGE_W = $clog2(DUTY_RANGE + 1);
  localparam int unsigned SCALE_W = ABS_W + RANGE_W;
  localparam int unsigned MAG_W   = SCALE_W - SCALE_SHIFT;
  localparam int unsigned DELTA_W = DUTY_W + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_LIMIT    = 3'd0,
    REG_PROP_GAIN      = 3'd1,
    REG_INTEG_GAIN     = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_SLEW_STEP      = 3'd4
  } dpsc_reg_e;

  localparam logic [LIM_W-1:0]  RST_SPEED_LIMIT    = 23'd8388607;
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN      = 24'd817455;
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN     = 24'd8806;
  localparam logic [LIM_W-1:0]  RST_INTEGRAL_LIMIT = 23'd122880;
  localparam logic [SLEW_W-1:0] RST_SLEW_STEP      = 9'd250;

  typedef struct packed {
    logic [LIM_W-1:0]  speed_limit;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [LIM_W-1:0]  integral_limit;
    logic [SLEW_W-1:0] slew_step;
  } dpsc_cfg_t;

  // Per-stage load strobes shared by both lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } dpsc_adv_t;

endpackage

FILE: rtl/dpsc_if.sv
// Valid/ready channel interfaces for the dual PI speed controller:
// the speed sample input and the duty/pin output. Depends on dpsc_pkg.
interface dpsc_in_if import dpsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] meas_left;
  logic signed [SPEED_W-1:0] meas_right;
  logic signed [SPEED_W-1:0] target_left;
  logic signed [SPEED_W-1:0] target_right;

  modport source (output valid, meas_left, meas_right, target_left, target_right,
                  input ready);
  modport sink   (input valid, meas_left, meas_right, target_left, target_right,
                  output ready);
endinterface

interface dpsc_out_if import dpsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DUTY_W-1:0] duty_left;
  logic signed [DUTY_W-1:0] duty_right;
  logic        [PWM_W-1:0]  pwm_left;
  logic        [PWM_W-1:0]  pwm_right;
  logic                     in1_left;
  logic                     in2_left;
  logic                     in1_right;
  logic                     in2_right;

  modport source (output valid, duty_left, duty_right, pwm_left, pwm_right,
                  in1_left, in2_left, in1_right, in2_right,
                  input ready);
  modport sink   (input valid, duty_left, duty_right, pwm_left, pwm_right,
                  in1_left, in2_left, in1_right, in2_right,
                  output ready);
endinterface

FILE: rtl/dpsc_lane.sv
// One PI lane: speed clamp, saturating integral, gain products, scaling
// to a target duty over four stages. Depends on dpsc_pkg.
module dpsc_lane import dpsc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dpsc_adv_t                 adv_i,
  input  dpsc_cfg_t                 cfg_i,
  input  logic signed [SPEED_W-1:0] meas_i,
  input  logic signed [SPEED_W-1:0] target_i,
  output logic signed [DUTY_W-1:0]  duty_o
);

  // Stage 1: clamp, error, integral
  logic signed [ERR_W-1:0]   lim_s, meas_x, meas_c, err_d;
  logic signed [ISUM_W-1:0]  ilim_s, isum;
  logic signed [INTEG_W-1:0] integ_d, integ_q;
  logic signed [ERR_W-1:0]   err_q;

  assign lim_s  = $signed({{(ERR_W-LIM_W){1'b0}}, cfg_i.speed_limit});
  assign meas_x = ERR_W'(meas_i);

  always_comb begin
    if (meas_x > lim_s) begin
      meas_c = lim_s;
    end else if (meas_x < -lim_s) begin
      meas_c = -lim_s;
    end else begin
      meas_c = meas_x;
    end
    err_d = ERR_W'(target_i) - meas_c;
  end

  assign ilim_s = $signed({{(ISUM_W-LIM_W){1'b0}}, cfg_i.integral_limit});
  assign isum   = ISUM_W'(integ_q) + ISUM_W'(err_d);

  always_comb begin
    if (isum > ilim_s) begin
      integ_d = ilim_s[INTEG_W-1:0];
    end else if (isum < -ilim_s) begin
      integ_d = INTEG_W'(-ilim_s);
    end else begin
      integ_d = isum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (adv_i.s1) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      err_q <= err_d;
    end
  end

  // Stage 2: gain products
  logic signed [GAIN_W:0]   kp_s, ki_s;
  logic signed [PROD_W-1:0] pp_d, pi_d, pp_q, pi_q;

  assign kp_s = $signed({1'b0, cfg_i.prop_gain});
  assign ki_s = $signed({1'b0, cfg_i.integ_gain});
  assign pp_d = kp_s * err_q;
  assign pi_d = ki_s * integ_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      pp_q <= pp_d;
      pi_q <= pi_d;
    end
  end

  // Stage 3: sum and take magnitude
  logic signed [SUM_W-1:0] sum;
  logic        [SUM_W-1:0] abs_full;
  logic        [ABS_W-1:0] abs_q;
  logic                    neg_q;

  assign sum      = SUM_W'(pp_q) + SUM_W'(pi_q);
  assign abs_full = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      abs_q <= abs_full[ABS_W-1:0];
      neg_q <= sum[SUM_W-1];
    end
  end

  // Stage 4: scale by duty range, truncate toward zero, clamp
  logic [SCALE_W-1:0] scaled;
  logic [MAG_W-1:0]   mag;
  logic [DUTY_W-1:0]  mag_c;
  logic signed [DUTY_W-1:0] duty_d, duty_q;

  assign scaled = SCALE_W'(abs_q) * SCALE_W'(DUTY_RANGE);
  assign mag    = scaled[SCALE_W-1:SCALE_SHIFT];

  always_comb begin
    if (mag > MAG_W'(DUTY_RANGE)) begin
      mag_c = DUTY_W'(DUTY_RANGE);
    end else begin
      mag_c = mag[DUTY_W-1:0];
    end
    duty_d = neg_q ? -$signed(mag_c) : $signed(mag_c);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule

FILE: rtl/dpsc_merge.sv
// Output stage: slews both applied duties toward the lane targets and
// forms PWM magnitudes and bridge pins. Depends on dpsc_pkg, dpsc_if.
module dpsc_merge import dpsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [SLEW_W-1:0]        slew_step_i,
  input  logic signed [DUTY_W-1:0] target_left_i,
  input  logic signed [DUTY_W-1:0] target_right_i,
  dpsc_out_if.source               out_o
);

  logic                     valid_q, valid_d;
  logic signed [DUTY_W-1:0] left_q, left_d, right_q, right_d;
  logic signed [DELTA_W-1:0] step_s;

  assign step_s = $signed({1'b0, slew_step_i});

  function automatic logic signed [DUTY_W-1:0] slew(
    input logic signed [DUTY_W-1:0]  target,
    input logic signed [DUTY_W-1:0]  applied,
    input logic signed [DELTA_W-1:0] step
  );
    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W-1:0] next;
    delta = DELTA_W'(target) - DELTA_W'(applied);
    if (delta > step) begin
      delta = step;
    end else if (delta < -step) begin
      delta = -step;
    end
    next = DELTA_W'(applied) + delta;
    return next[DUTY_W-1:0];
  endfunction

  assign left_d  = slew(target_left_i, left_q, step_s);
  assign right_d = slew(target_right_i, right_q, step_s);
  assign valid_d = load_i | (valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= '0;
      right_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (load_i) begin
        left_q  <= left_d;
        right_q <= right_d;
      end
    end
  end

  logic [DUTY_W-1:0] abs_l, abs_r;

  assign abs_l = left_q[DUTY_W-1]  ? DUTY_W'(-left_q)  : DUTY_W'(left_q);
  assign abs_r = right_q[DUTY_W-1] ? DUTY_W'(-right_q) : DUTY_W'(right_q);

  assign out_o.valid      = valid_q;
  assign out_o.duty_left  = left_q;
  assign out_o.duty_right = right_q;
  assign out_o.pwm_left   = abs_l[PWM_W-1:0];
  assign out_o.pwm_right  = abs_r[PWM_W-1:0];
  // Left bridge is wired mirrored
  assign out_o.in1_left   = left_q[DUTY_W-1];
  assign out_o.in2_left   = ~left_q[DUTY_W-1];
  assign out_o.in1_right  = ~right_q[DUTY_W-1];
  assign out_o.in2_right  = right_q[DUTY_W-1];

endmodule

FILE: rtl/dual_pi_speed_controller_unit.sv
// Top level of the dual PI speed controller: configuration registers,
// pipeline valid tracking, two PI lanes and the output merge stage.
// Depends on dpsc_pkg, dpsc_if, dpsc_lane and dpsc_merge.
//
//   Channel | Direction | Handshake     | Payload
//   --------+-----------+---------------+-------------------------------------
//   in_i    | sink      | valid/ready   | meas_left/right, target_left/right
//   out_o   | source    | valid/ready   | duty_*, pwm_*, in1_*/in2_* pins
//   cfg     | sink      | cfg_we_i only | cfg_idx_i, cfg_data_i
//
// One item per clock while out_o is not stalled; an accepted item passes the
// four lane stages and then the output register before it shows on out_o, the
// first lane stage loading at the accepting edge.
// Each stage holds its item only while the next stage is full and stalled,
// so bubbles collapse and an input item is taken while a result waits.
// Reset clears the integrals, applied duties and all valid bits at once and
// loads the register defaults; no clearing pass is needed.
module dual_pi_speed_controller_unit import dpsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dpsc_in_if.sink               in_i,
  dpsc_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers: unknown indexes drop the write, wide data
  // keeps only the register's low bits.
  // ---------------------------------------------------------------------
  dpsc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit    <= RST_SPEED_LIMIT;
      cfg_q.prop_gain      <= RST_PROP_GAIN;
      cfg_q.integ_gain     <= RST_INTEG_GAIN;
      cfg_q.integral_limit <= RST_INTEGRAL_LIMIT;
      cfg_q.slew_step      <= RST_SLEW_STEP;
    end else if (cfg_we_i) begin
      unique case (dpsc_reg_e'(cfg_idx_i))
        REG_SPEED_LIMIT:    cfg_q.speed_limit    <= cfg_data_i[LIM_W-1:0];
        REG_PROP_GAIN:      cfg_q.prop_gain      <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN:     cfg_q.integ_gain     <= cfg_data_i[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data_i[LIM_W-1:0];
        REG_SLEW_STEP:      cfg_q.slew_step      <= cfg_data_i[SLEW_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control. A stage loads when the one before it holds an item
  // and it is itself empty or emptying this cycle. Evaluate from the
  // output back to the input.
  // ---------------------------------------------------------------------
  logic [3:0] vld_q, vld_d;
  logic       load_out;
  logic       free1, free2, free3, free4;
  dpsc_adv_t  adv;

  assign load_out = vld_q[3] & (~out_o.valid | out_o.ready);
  assign free4    = ~vld_q[3] | load_out;
  assign adv.s4   = vld_q[2] & free4;
  assign free3    = ~vld_q[2] | adv.s4;
  assign adv.s3   = vld_q[1] & free3;
  assign free2    = ~vld_q[1] | adv.s3;
  assign adv.s2   = vld_q[0] & free2;
  assign free1    = ~vld_q[0] | adv.s2;
  assign adv.s1   = in_i.valid & free1;

  assign in_i.ready = free1;

  // A stage stays full if it loads, or if it held an item that did not move on
  always_comb begin
    vld_d[0] = adv.s1 | (vld_q[0] & ~adv.s2);
    vld_d[1] = adv.s2 | (vld_q[1] & ~adv.s3);
    vld_d[2] = adv.s3 | (vld_q[2] & ~adv.s4);
    vld_d[3] = adv.s4 | (vld_q[3] & ~load_out);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------
  // Two identical PI lanes, one per wheel
  // ---------------------------------------------------------------------
  logic signed [DUTY_W-1:0] target_l, target_r;

  dpsc_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .cfg_i    (cfg_q),
    .meas_i   (in_i.meas_left),
    .target_i (in_i.target_left),
    .duty_o   (target_l)
  );

  dpsc_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .cfg_i    (cfg_q),
    .meas_i   (in_i.meas_right),
    .target_i (in_i.target_right),
    .duty_o   (target_r)
  );

  // ---------------------------------------------------------------------
  // Merge: slew limit, PWM magnitude, bridge pins, output register
  // ---------------------------------------------------------------------
  dpsc_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load_out),
    .slew_step_i    (cfg_q.slew_step),
    .target_left_i  (target_l),
    .target_right_i (target_r),
    .out_o          (out_o)
  );

endmodule
